// ===== hw/rtl/stt_pkg.sv =====
// Shared widths and codes for the sphere-triangle test pipeline.
// Used by the top level and by the pipelined divider; no dependencies.
`default_nettype none
package stt_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIF_W      = COORD_BITS + 1;
    localparam int DOT_W      = 2 * COORD_BITS + 3;
    localparam int DOT_LO     = DOT_W / 2;
    localparam int DOT_HI     = DOT_W - DOT_LO;
    localparam int PROD_W     = 2 * DOT_W;
    localparam int VW         = PROD_W + 1;
    localparam int SEG        = (VW + 2) / 3;
    localparam int SEG_HI     = VW - 2 * SEG;
    localparam int DEN_W      = VW + 2;
    localparam int TRM_W      = VW + DIF_W;
    localparam int NUM_W      = TRM_W + 1;
    localparam int REM_W      = NUM_W + 2;
    localparam int QB         = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIF_W + 2;

    typedef enum logic [2:0] {
        RG_VERT_A,
        RG_VERT_B,
        RG_VERT_C,
        RG_EDGE_AB,
        RG_EDGE_AC,
        RG_EDGE_BC,
        RG_FACE
    } region_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow clamp.
// Depends on stt_pkg for its widths.
`default_nettype none
module stt_div (
    input  wire logic                        clk,
    input  wire logic [stt_pkg::REM_W-1:0]   num,
    input  wire logic [stt_pkg::DEN_W-1:0]   dvs,
    output logic      [stt_pkg::QB-1:0]      quot
);

    localparam int REM_W = stt_pkg::REM_W;
    localparam int DEN_W = stt_pkg::DEN_W;
    localparam int QB    = stt_pkg::QB;

    logic [REM_W-1:0] rem_reg [QB];
    logic [DEN_W-1:0] dv_reg  [QB];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             ovf_reg [QB+1];
    logic [REM_W-1:0] lim_next;

    assign lim_next = REM_W'(dvs) << stt_pkg::COORD_BITS;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        dv_reg[0]  <= dvs;
        q_reg[0]   <= '0;
        ovf_reg[0] <= (num >= lim_next);
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [REM_W-1:0] sub_next;
        logic [REM_W-1:0] rem_next;
        logic             bit_next;

        always_comb
        begin
            sub_next = REM_W'(dv_reg[i-1]) << (QB - i);
            bit_next = (rem_reg[i-1] >= sub_next);
            rem_next = bit_next ? (rem_reg[i-1] - sub_next) : rem_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            q_reg[i]   <= q_reg[i-1] | (QB'(bit_next) << (QB - i));
            ovf_reg[i] <= ovf_reg[i-1];
        end

        if (i < QB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                dv_reg[i]  <= dv_reg[i-1];
            end
        end
    end

    assign quot = ovf_reg[QB] ? (QB'(1) << stt_pkg::COORD_BITS) : q_reg[QB];

endmodule
`default_nettype wire

// ===== hw/rtl/sphere_triangle_test.sv =====
// Sphere-triangle overlap test that reports the closest triangle point on a hit, and zero otherwise.
// An accepted item passes stages s0 to s9, the divider delay line and stages f1 and f2 before done.
// One item may start in every cycle; busy is always low since nothing stalls.
// The divide for edge and face points is a pipelined divider with one bit per stage.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// Depends on stt_pkg and stt_div.
`default_nettype none
module sphere_triangle_test (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [3*stt_pkg::COORD_BITS-1:0]    sphere_center,
    input  wire logic [stt_pkg::COORD_BITS-1:0]      sphere_radius,
    input  wire logic [3*stt_pkg::COORD_BITS-1:0]    vertex_a,
    input  wire logic [3*stt_pkg::COORD_BITS-1:0]    vertex_b,
    input  wire logic [3*stt_pkg::COORD_BITS-1:0]    vertex_c,
    output logic                                     done,
    output logic                                     hit,
    output logic [3*stt_pkg::COORD_BITS-1:0]         closest_point
);

    localparam int W      = stt_pkg::COORD_BITS;
    localparam int DIF_W  = stt_pkg::DIF_W;
    localparam int DOT_W  = stt_pkg::DOT_W;
    localparam int DOT_LO = stt_pkg::DOT_LO;
    localparam int DOT_HI = stt_pkg::DOT_HI;
    localparam int PROD_W = stt_pkg::PROD_W;
    localparam int VW     = stt_pkg::VW;
    localparam int SEG    = stt_pkg::SEG;
    localparam int SEG_HI = stt_pkg::SEG_HI;
    localparam int DEN_W  = stt_pkg::DEN_W;
    localparam int TRM_W  = stt_pkg::TRM_W;
    localparam int NUM_W  = stt_pkg::NUM_W;
    localparam int REM_W  = stt_pkg::REM_W;
    localparam int QB     = stt_pkg::QB;
    localparam int SQ_W   = stt_pkg::SQ_W;
    localparam int LO_W   = SEG + 1 + DIF_W;
    localparam int HI_W   = SEG_HI + DIF_W;
    localparam int LAT    = QB + 14;
    localparam int MX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MY [6] = '{3, 1, 1, 5, 5, 3};
    localparam logic signed [W+1:0] SAT_HI = (W+2)'(2**(W-1) - 1);
    localparam logic signed [W+1:0] SAT_LO = (W+2)'(-(2**(W-1)));

    function automatic logic signed [DOT_W-1:0] dot3(
        input logic signed [DIF_W-1:0] u0,
        input logic signed [DIF_W-1:0] u1,
        input logic signed [DIF_W-1:0] u2,
        input logic signed [DIF_W-1:0] v0,
        input logic signed [DIF_W-1:0] v1,
        input logic signed [DIF_W-1:0] v2
    );
        logic signed [2*DIF_W-1:0] m0;
        logic signed [2*DIF_W-1:0] m1;
        logic signed [2*DIF_W-1:0] m2;
        m0 = u0 * v0;
        m1 = u1 * v1;
        m2 = u2 * v2;
        return DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);
    endfunction

    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg;
    logic dl_vld_reg [QB+1];
    logic f1_vld_reg, f2_vld_reg, done_reg;

    logic signed [W-1:0] s0_p_reg [3], s0_a_reg [3], s0_b_reg [3], s0_c_reg [3];
    logic [W-1:0]        s0_rad_reg;

    logic signed [DIF_W-1:0] s1_e1_reg [3], s1_e2_reg [3], s1_bc_reg [3];
    logic signed [DIF_W-1:0] s1_ap_reg [3], s1_bp_reg [3], s1_cp_reg [3];
    logic signed [W-1:0]     s1_p_reg [3], s1_a_reg [3], s1_b_reg [3], s1_c_reg [3];
    logic [W-1:0]            s1_rad_reg;

    logic signed [DOT_W-1:0] s2_d_reg [6];
    logic signed [DIF_W-1:0] s2_e1_reg [3], s2_e2_reg [3], s2_bc_reg [3];
    logic signed [W-1:0]     s2_p_reg [3], s2_a_reg [3], s2_b_reg [3], s2_c_reg [3];
    logic [W-1:0]            s2_rad_reg;

    logic signed [DOT_W+DOT_HI-1:0]   s3_ph_reg [6];
    logic signed [DOT_W+DOT_LO:0]     s3_pl_reg [6];
    logic signed [DOT_W-1:0]          s3_d_reg [6];
    logic signed [DIF_W-1:0] s3_e1_reg [3], s3_e2_reg [3], s3_bc_reg [3];
    logic signed [W-1:0]     s3_p_reg [3], s3_a_reg [3], s3_b_reg [3], s3_c_reg [3];
    logic [W-1:0]            s3_rad_reg;

    logic signed [PROD_W-1:0] prod_next [6];
    logic signed [VW-1:0]     s4_va_reg, s4_vb_reg, s4_vc_reg;
    logic signed [DOT_W-1:0]  s4_d_reg [6];
    logic signed [DIF_W-1:0]  s4_e1_reg [3], s4_e2_reg [3], s4_bc_reg [3];
    logic signed [W-1:0]      s4_p_reg [3], s4_a_reg [3], s4_b_reg [3], s4_c_reg [3];
    logic [W-1:0]             s4_rad_reg;

    stt_pkg::region_t          rg_next;
    logic signed [DOT_W:0]     d43_next, d56_next, den_ab_next, den_ac_next;
    logic signed [DOT_W+1:0]   den_bc_next;
    logic signed [DEN_W-1:0]   den_f_next;
    logic                      use_div_next;
    logic signed [W-1:0]       pd_next [3], base_next [3];
    logic signed [VW-1:0]      s1v_next, s2v_next;
    logic signed [DIF_W-1:0]   x_next [3], y_next [3];
    logic signed [DEN_W-1:0]   den_next;

    logic                    s5_use_div_reg;
    logic signed [W-1:0]     s5_pd_reg [3], s5_base_reg [3], s5_p_reg [3];
    logic signed [VW-1:0]    s5_s1_reg, s5_s2_reg;
    logic signed [DIF_W-1:0] s5_x_reg [3], s5_y_reg [3];
    logic signed [DEN_W-1:0] s5_den_reg;
    logic [W-1:0]            s5_rad_reg;

    logic signed [LO_W-1:0]  s6_pl1_reg [3], s6_pm1_reg [3], s6_pl2_reg [3], s6_pm2_reg [3];
    logic signed [HI_W-1:0]  s6_ph1_reg [3], s6_ph2_reg [3];
    logic                    s6_use_div_reg;
    logic signed [W-1:0]     s6_pd_reg [3], s6_base_reg [3], s6_p_reg [3];
    logic signed [DEN_W-1:0] s6_den_reg;
    logic [W-1:0]            s6_rad_reg;

    logic signed [TRM_W-1:0] s7_t1_reg [3], s7_t2_reg [3];
    logic                    s7_use_div_reg;
    logic signed [W-1:0]     s7_pd_reg [3], s7_base_reg [3], s7_p_reg [3];
    logic signed [DEN_W-1:0] s7_den_reg;
    logic [W-1:0]            s7_rad_reg;

    logic signed [NUM_W-1:0] s8_n_reg [3];
    logic                    s8_use_div_reg;
    logic signed [W-1:0]     s8_pd_reg [3], s8_base_reg [3], s8_p_reg [3];
    logic signed [DEN_W-1:0] s8_den_reg;
    logic [W-1:0]            s8_rad_reg;

    logic [NUM_W-1:0]        mag_next [3];
    logic [DEN_W-1:0]        den_u_next;
    logic [REM_W-1:0]        s9_nn_reg [3];
    logic [DEN_W-1:0]        s9_dv_reg;
    logic                    s9_neg_reg [3];
    logic                    s9_use_div_reg;
    logic signed [W-1:0]     s9_pd_reg [3], s9_base_reg [3], s9_p_reg [3];
    logic [W-1:0]            s9_rad_reg;

    logic                    dl_neg_reg [QB+1][3];
    logic                    dl_use_reg [QB+1];
    logic signed [W-1:0]     dl_pd_reg [QB+1][3], dl_base_reg [QB+1][3], dl_p_reg [QB+1][3];
    logic [W-1:0]            dl_rad_reg [QB+1];

    logic [QB-1:0]           quot [3];
    logic signed [W+1:0]     sum_next [3];
    logic signed [W-1:0]     pt_next [3];
    logic signed [W-1:0]     f1_pt_reg [3], f1_p_reg [3];
    logic [W-1:0]            f1_rad_reg;

    logic signed [DIF_W-1:0]   v_next [3];
    logic signed [2*DIF_W-1:0] sq_next [3];
    logic [2*DIF_W-1:0]        f2_sq_reg [3];
    logic [2*W-1:0]            f2_r2_reg;
    logic signed [W-1:0]       f2_pt_reg [3];

    logic [SQ_W-1:0]         dist_next;
    logic                    hit_next;
    logic                    hit_reg;
    logic [3*W-1:0]          cp_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            s9_vld_reg <= 1'b0;
            for (int i = 0; i <= QB; i++)
            begin
                dl_vld_reg[i] <= 1'b0;
            end
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
            s9_vld_reg <= s8_vld_reg;
            dl_vld_reg[0] <= s9_vld_reg;
            for (int i = 1; i <= QB; i++)
            begin
                dl_vld_reg[i] <= dl_vld_reg[i-1];
            end
            f1_vld_reg <= dl_vld_reg[QB];
            f2_vld_reg <= f1_vld_reg;
            done_reg   <= f2_vld_reg;
        end
    end

    // Input registers and edge vectors.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s0_p_reg[k] <= sphere_center[(2-k)*W +: W];
            s0_a_reg[k] <= vertex_a[(2-k)*W +: W];
            s0_b_reg[k] <= vertex_b[(2-k)*W +: W];
            s0_c_reg[k] <= vertex_c[(2-k)*W +: W];

            s1_e1_reg[k] <= DIF_W'(s0_b_reg[k]) - DIF_W'(s0_a_reg[k]);
            s1_e2_reg[k] <= DIF_W'(s0_c_reg[k]) - DIF_W'(s0_a_reg[k]);
            s1_bc_reg[k] <= DIF_W'(s0_c_reg[k]) - DIF_W'(s0_b_reg[k]);
            s1_ap_reg[k] <= DIF_W'(s0_p_reg[k]) - DIF_W'(s0_a_reg[k]);
            s1_bp_reg[k] <= DIF_W'(s0_p_reg[k]) - DIF_W'(s0_b_reg[k]);
            s1_cp_reg[k] <= DIF_W'(s0_p_reg[k]) - DIF_W'(s0_c_reg[k]);
            s1_p_reg[k]  <= s0_p_reg[k];
            s1_a_reg[k]  <= s0_a_reg[k];
            s1_b_reg[k]  <= s0_b_reg[k];
            s1_c_reg[k]  <= s0_c_reg[k];
        end
        s0_rad_reg <= sphere_radius;
        s1_rad_reg <= s0_rad_reg;
    end

    // Dot products d1 to d6.
    always_ff @(posedge clk)
    begin
        s2_d_reg[0] <= dot3(s1_e1_reg[0], s1_e1_reg[1], s1_e1_reg[2],
                            s1_ap_reg[0], s1_ap_reg[1], s1_ap_reg[2]);
        s2_d_reg[1] <= dot3(s1_e2_reg[0], s1_e2_reg[1], s1_e2_reg[2],
                            s1_ap_reg[0], s1_ap_reg[1], s1_ap_reg[2]);
        s2_d_reg[2] <= dot3(s1_e1_reg[0], s1_e1_reg[1], s1_e1_reg[2],
                            s1_bp_reg[0], s1_bp_reg[1], s1_bp_reg[2]);
        s2_d_reg[3] <= dot3(s1_e2_reg[0], s1_e2_reg[1], s1_e2_reg[2],
                            s1_bp_reg[0], s1_bp_reg[1], s1_bp_reg[2]);
        s2_d_reg[4] <= dot3(s1_e1_reg[0], s1_e1_reg[1], s1_e1_reg[2],
                            s1_cp_reg[0], s1_cp_reg[1], s1_cp_reg[2]);
        s2_d_reg[5] <= dot3(s1_e2_reg[0], s1_e2_reg[1], s1_e2_reg[2],
                            s1_cp_reg[0], s1_cp_reg[1], s1_cp_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            s2_e1_reg[k] <= s1_e1_reg[k];
            s2_e2_reg[k] <= s1_e2_reg[k];
            s2_bc_reg[k] <= s1_bc_reg[k];
            s2_p_reg[k]  <= s1_p_reg[k];
            s2_a_reg[k]  <= s1_a_reg[k];
            s2_b_reg[k]  <= s1_b_reg[k];
            s2_c_reg[k]  <= s1_c_reg[k];
        end
        s2_rad_reg <= s1_rad_reg;
    end

    // Partial products of the region determinants, second operand split in two.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            s3_ph_reg[j] <= s2_d_reg[MX[j]] * $signed(s2_d_reg[MY[j]][DOT_W-1:DOT_LO]);
            s3_pl_reg[j] <= s2_d_reg[MX[j]] * $signed({1'b0, s2_d_reg[MY[j]][DOT_LO-1:0]});
            s3_d_reg[j]  <= s2_d_reg[j];
        end
        for (int k = 0; k < 3; k++)
        begin
            s3_e1_reg[k] <= s2_e1_reg[k];
            s3_e2_reg[k] <= s2_e2_reg[k];
            s3_bc_reg[k] <= s2_bc_reg[k];
            s3_p_reg[k]  <= s2_p_reg[k];
            s3_a_reg[k]  <= s2_a_reg[k];
            s3_b_reg[k]  <= s2_b_reg[k];
            s3_c_reg[k]  <= s2_c_reg[k];
        end
        s3_rad_reg <= s2_rad_reg;
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            prod_next[j] = (PROD_W'(s3_ph_reg[j]) <<< DOT_LO) + PROD_W'(s3_pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        s4_vc_reg <= VW'(prod_next[0]) - VW'(prod_next[1]);
        s4_vb_reg <= VW'(prod_next[2]) - VW'(prod_next[3]);
        s4_va_reg <= VW'(prod_next[4]) - VW'(prod_next[5]);
        for (int j = 0; j < 6; j++)
        begin
            s4_d_reg[j] <= s3_d_reg[j];
        end
        for (int k = 0; k < 3; k++)
        begin
            s4_e1_reg[k] <= s3_e1_reg[k];
            s4_e2_reg[k] <= s3_e2_reg[k];
            s4_bc_reg[k] <= s3_bc_reg[k];
            s4_p_reg[k]  <= s3_p_reg[k];
            s4_a_reg[k]  <= s3_a_reg[k];
            s4_b_reg[k]  <= s3_b_reg[k];
            s4_c_reg[k]  <= s3_c_reg[k];
        end
        s4_rad_reg <= s3_rad_reg;
    end

    // Region selection, checked in the order vertex a, vertex b, edge ab,
    // vertex c, edge ac, edge bc, and then the face.
    always_comb
    begin
        d43_next    = (DOT_W+1)'(s4_d_reg[3]) - (DOT_W+1)'(s4_d_reg[2]);
        d56_next    = (DOT_W+1)'(s4_d_reg[4]) - (DOT_W+1)'(s4_d_reg[5]);
        den_ab_next = (DOT_W+1)'(s4_d_reg[0]) - (DOT_W+1)'(s4_d_reg[2]);
        den_ac_next = (DOT_W+1)'(s4_d_reg[1]) - (DOT_W+1)'(s4_d_reg[5]);
        den_bc_next = (DOT_W+2)'(d43_next) + (DOT_W+2)'(d56_next);
        den_f_next  = DEN_W'(s4_va_reg) + DEN_W'(s4_vb_reg) + DEN_W'(s4_vc_reg);

        if (s4_d_reg[0] <= 0 && s4_d_reg[1] <= 0)
            rg_next = stt_pkg::RG_VERT_A;
        else if (s4_d_reg[2] >= 0 && s4_d_reg[3] <= s4_d_reg[2])
            rg_next = stt_pkg::RG_VERT_B;
        else if (s4_vc_reg <= 0 && s4_d_reg[0] >= 0 && s4_d_reg[2] <= 0)
            rg_next = stt_pkg::RG_EDGE_AB;
        else if (s4_d_reg[5] >= 0 && s4_d_reg[4] <= s4_d_reg[5])
            rg_next = stt_pkg::RG_VERT_C;
        else if (s4_vb_reg <= 0 && s4_d_reg[1] >= 0 && s4_d_reg[5] <= 0)
            rg_next = stt_pkg::RG_EDGE_AC;
        else if (s4_va_reg <= 0 && d43_next >= 0 && d56_next >= 0)
            rg_next = stt_pkg::RG_EDGE_BC;
        else
            rg_next = stt_pkg::RG_FACE;

        use_div_next = 1'b0;
        s1v_next     = '0;
        s2v_next     = '0;
        den_next     = den_f_next;
        for (int k = 0; k < 3; k++)
        begin
            pd_next[k]   = s4_a_reg[k];
            base_next[k] = s4_a_reg[k];
            x_next[k]    = s4_e1_reg[k];
            y_next[k]    = s4_e2_reg[k];
        end

        unique case (rg_next)
            stt_pkg::RG_VERT_A:
            begin
            end
            stt_pkg::RG_VERT_B:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pd_next[k] = s4_b_reg[k];
                end
            end
            stt_pkg::RG_VERT_C:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pd_next[k] = s4_c_reg[k];
                end
            end
            stt_pkg::RG_EDGE_AB:
            begin
                use_div_next = (den_ab_next > 0);
                s1v_next     = VW'(s4_d_reg[0]);
                den_next     = DEN_W'(den_ab_next);
            end
            stt_pkg::RG_EDGE_AC:
            begin
                use_div_next = (den_ac_next > 0);
                s1v_next     = VW'(s4_d_reg[1]);
                den_next     = DEN_W'(den_ac_next);
                for (int k = 0; k < 3; k++)
                begin
                    x_next[k] = s4_e2_reg[k];
                end
            end
            stt_pkg::RG_EDGE_BC:
            begin
                use_div_next = (den_bc_next > 0);
                s1v_next     = VW'(d43_next);
                den_next     = DEN_W'(den_bc_next);
                for (int k = 0; k < 3; k++)
                begin
                    x_next[k]    = s4_bc_reg[k];
                    base_next[k] = s4_b_reg[k];
                end
            end
            stt_pkg::RG_FACE:
            begin
                use_div_next = (den_f_next > 0);
                s1v_next     = s4_vb_reg;
                s2v_next     = s4_vc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s5_use_div_reg <= use_div_next;
        s5_s1_reg      <= s1v_next;
        s5_s2_reg      <= s2v_next;
        s5_den_reg     <= den_next;
        for (int k = 0; k < 3; k++)
        begin
            s5_pd_reg[k]   <= pd_next[k];
            s5_base_reg[k] <= base_next[k];
            s5_x_reg[k]    <= x_next[k];
            s5_y_reg[k]    <= y_next[k];
            s5_p_reg[k]    <= s4_p_reg[k];
        end
        s5_rad_reg <= s4_rad_reg;
    end

    // Numerator partial products, the scale factors cut into three segments.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s6_pl1_reg[k]  <= $signed({1'b0, s5_s1_reg[SEG-1:0]}) * s5_x_reg[k];
            s6_pm1_reg[k]  <= $signed({1'b0, s5_s1_reg[2*SEG-1:SEG]}) * s5_x_reg[k];
            s6_ph1_reg[k]  <= $signed(s5_s1_reg[VW-1:2*SEG]) * s5_x_reg[k];
            s6_pl2_reg[k]  <= $signed({1'b0, s5_s2_reg[SEG-1:0]}) * s5_y_reg[k];
            s6_pm2_reg[k]  <= $signed({1'b0, s5_s2_reg[2*SEG-1:SEG]}) * s5_y_reg[k];
            s6_ph2_reg[k]  <= $signed(s5_s2_reg[VW-1:2*SEG]) * s5_y_reg[k];
            s6_pd_reg[k]   <= s5_pd_reg[k];
            s6_base_reg[k] <= s5_base_reg[k];
            s6_p_reg[k]    <= s5_p_reg[k];
        end
        s6_use_div_reg <= s5_use_div_reg;
        s6_den_reg     <= s5_den_reg;
        s6_rad_reg     <= s5_rad_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s7_t1_reg[k] <= (TRM_W'(s6_ph1_reg[k]) <<< (2*SEG))
                          + (TRM_W'(s6_pm1_reg[k]) <<< SEG) + TRM_W'(s6_pl1_reg[k]);
            s7_t2_reg[k] <= (TRM_W'(s6_ph2_reg[k]) <<< (2*SEG))
                          + (TRM_W'(s6_pm2_reg[k]) <<< SEG) + TRM_W'(s6_pl2_reg[k]);
            s7_pd_reg[k]   <= s6_pd_reg[k];
            s7_base_reg[k] <= s6_base_reg[k];
            s7_p_reg[k]    <= s6_p_reg[k];
        end
        s7_use_div_reg <= s6_use_div_reg;
        s7_den_reg     <= s6_den_reg;
        s7_rad_reg     <= s6_rad_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s8_n_reg[k]    <= NUM_W'(s7_t1_reg[k]) + NUM_W'(s7_t2_reg[k]);
            s8_pd_reg[k]   <= s7_pd_reg[k];
            s8_base_reg[k] <= s7_base_reg[k];
            s8_p_reg[k]    <= s7_p_reg[k];
        end
        s8_use_div_reg <= s7_use_div_reg;
        s8_den_reg     <= s7_den_reg;
        s8_rad_reg     <= s7_rad_reg;
    end

    // Rounded quotient is floor((2|n| + den) / (2 den)), ties away from zero.
    always_comb
    begin
        den_u_next = s8_den_reg;
        for (int k = 0; k < 3; k++)
        begin
            mag_next[k] = s8_n_reg[k][NUM_W-1] ? NUM_W'(-s8_n_reg[k]) : NUM_W'(s8_n_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s9_nn_reg[k]   <= (REM_W'(mag_next[k]) << 1) + REM_W'(den_u_next);
            s9_neg_reg[k]  <= s8_n_reg[k][NUM_W-1];
            s9_pd_reg[k]   <= s8_pd_reg[k];
            s9_base_reg[k] <= s8_base_reg[k];
            s9_p_reg[k]    <= s8_p_reg[k];
        end
        s9_dv_reg      <= den_u_next << 1;
        s9_use_div_reg <= s8_use_div_reg;
        s9_rad_reg     <= s8_rad_reg;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        stt_div u_div (
            .clk  (clk),
            .num  (s9_nn_reg[g]),
            .dvs  (s9_dv_reg),
            .quot (quot[g])
        );
    end

    always_ff @(posedge clk)
    begin
        dl_use_reg[0] <= s9_use_div_reg;
        dl_rad_reg[0] <= s9_rad_reg;
        for (int k = 0; k < 3; k++)
        begin
            dl_neg_reg[0][k]  <= s9_neg_reg[k];
            dl_pd_reg[0][k]   <= s9_pd_reg[k];
            dl_base_reg[0][k] <= s9_base_reg[k];
            dl_p_reg[0][k]    <= s9_p_reg[k];
        end
        for (int i = 1; i <= QB; i++)
        begin
            dl_use_reg[i] <= dl_use_reg[i-1];
            dl_rad_reg[i] <= dl_rad_reg[i-1];
            for (int k = 0; k < 3; k++)
            begin
                dl_neg_reg[i][k]  <= dl_neg_reg[i-1][k];
                dl_pd_reg[i][k]   <= dl_pd_reg[i-1][k];
                dl_base_reg[i][k] <= dl_base_reg[i-1][k];
                dl_p_reg[i][k]    <= dl_p_reg[i-1][k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dl_neg_reg[QB][k])
                sum_next[k] = (W+2)'(dl_base_reg[QB][k]) - $signed({1'b0, quot[k]});
            else
                sum_next[k] = (W+2)'(dl_base_reg[QB][k]) + $signed({1'b0, quot[k]});

            if (!dl_use_reg[QB])
                pt_next[k] = dl_pd_reg[QB][k];
            else if (sum_next[k] > SAT_HI)
                pt_next[k] = W'(SAT_HI);
            else if (sum_next[k] < SAT_LO)
                pt_next[k] = W'(SAT_LO);
            else
                pt_next[k] = W'(sum_next[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            f1_pt_reg[k] <= pt_next[k];
            f1_p_reg[k]  <= dl_p_reg[QB][k];
        end
        f1_rad_reg <= dl_rad_reg[QB];
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            v_next[k]  = DIF_W'(f1_pt_reg[k]) - DIF_W'(f1_p_reg[k]);
            sq_next[k] = v_next[k] * v_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            f2_sq_reg[k] <= $unsigned(sq_next[k]);
            f2_pt_reg[k] <= f1_pt_reg[k];
        end
        f2_r2_reg <= f1_rad_reg * f1_rad_reg;
    end

    always_comb
    begin
        dist_next = SQ_W'(f2_sq_reg[0]) + SQ_W'(f2_sq_reg[1]) + SQ_W'(f2_sq_reg[2]);
        hit_next  = (dist_next <= SQ_W'(f2_r2_reg));
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        cp_reg  <= hit_next ? {f2_pt_reg[0], f2_pt_reg[1], f2_pt_reg[2]} : '0;
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign closest_point = cp_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("accepted item produced no result at the expected cycle");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without a matching accepted item");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg && s5_use_div_reg |-> s5_den_reg > 0)
        else $error("divide selected with a denominator that is not positive");

endmodule
`default_nettype wire
